FILE: rtl/pidw_pkg.sv
package pidw_pkg;

    localparam int WINDOW_DEPTH_DEF = 25;
    localparam int GAIN_SCALE_DEF   = 10000;

    localparam int MEAS_W   = 8;
    localparam int CTRL_W   = 16;
    localparam int ENTRY_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int TARGET_W = 8;
    localparam int FRAME_W  = 10;
    localparam int GAIN_W   = 15;

    localparam int DIV_NUM_W = 32;
    localparam int DIV_DEN_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd4;

    localparam logic [TARGET_W-1:0] TARGET_RST = 8'd0;
    localparam logic [FRAME_W-1:0]  FRAME_RST  = 10'd101;
    localparam logic [GAIN_W-1:0]   GAIN_P_RST = 15'd10000;
    localparam logic [GAIN_W-1:0]   GAIN_I_RST = 15'd0;
    localparam logic [GAIN_W-1:0]   GAIN_D_RST = 15'd0;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: rtl/pidw_meas_if.sv
interface pidw_meas_if;
    logic                          valid;
    logic                          ready;
    logic [pidw_pkg::MEAS_W-1:0]   measured_value;

    modport source (output valid, output measured_value, input ready);
    modport sink (input valid, input measured_value, output ready);
endinterface

FILE: rtl/pidw_ctrl_if.sv
interface pidw_ctrl_if;
    logic                               valid;
    logic                               ready;
    logic signed [pidw_pkg::CTRL_W-1:0] control_value;

    modport source (output valid, output control_value, input ready);
    modport sink (input valid, input control_value, output ready);
endinterface

FILE: rtl/pidw_cfg_if.sv
interface pidw_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [pidw_pkg::CFG_IDX_W-1:0]    index;
    logic [pidw_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/pid_windowed_integral_controller.sv
// PID controller with a sliding-window integral term.
// Channels: meas (sink) takes one measured_value per request; ctrl (source)
// returns one control_value per request; cfg (sink) writes the setpoint,
// frame length and the three gains by index, always ready; the user must
// write it only while idle, as the block does not enforce this. One shared
// multiplier and one serial divider (two quotient bits a cycle, 16 steps)
// are sequenced through four divisions: P, I, derivative by frame length,
// and D. meas.ready is high only between requests, so a new request is not
// taken until the previous result has gone to the output register.
// The window of WINDOW_DEPTH scaled errors is a circular buffer with a fill
// count, a running 16-bit wrapped sum and the two newest entries in
// registers; entries not yet written read as zero.
// Reset: registers return to their reset values, the window reads empty,
// no clearing pass is needed.
// Stall: a result waits in the output register while ctrl.ready is low; the
// next request is accepted meanwhile and its result held until ctrl frees.
module pid_windowed_integral_controller #(
    parameter int WINDOW_DEPTH = pidw_pkg::WINDOW_DEPTH_DEF,
    parameter int GAIN_SCALE   = pidw_pkg::GAIN_SCALE_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    pidw_meas_if.sink  meas,
    pidw_ctrl_if.source ctrl,
    pidw_cfg_if.sink   cfg
);

    localparam int PTR_W   = $clog2(WINDOW_DEPTH);
    localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int ENTRY_W = pidw_pkg::ENTRY_W;
    localparam int NUM_W   = pidw_pkg::DIV_NUM_W;
    localparam int DEN_W   = pidw_pkg::DIV_DEN_W;
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(WINDOW_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(WINDOW_DEPTH);
    localparam logic [DEN_W-1:0] SCALE_DEN = DEN_W'(GAIN_SCALE);

    typedef enum logic [3:0] {
        S_IDLE, S_ENTRY, S_SHIFT, S_P_GO, S_P_WAIT, S_I_MUL, S_I_GO, S_I_WAIT,
        S_D_GO, S_D_WAIT, S_D_MUL, S_E_GO, S_E_WAIT, S_EMIT
    } state_t;

    state_t state_reg;

    logic [pidw_pkg::TARGET_W-1:0] target_reg;
    logic [pidw_pkg::FRAME_W-1:0]  frame_reg;
    logic [pidw_pkg::GAIN_W-1:0]   gain_p_reg;
    logic [pidw_pkg::GAIN_W-1:0]   gain_i_reg;
    logic [pidw_pkg::GAIN_W-1:0]   gain_d_reg;

    logic [ENTRY_W-1:0] mem [WINDOW_DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;
    logic [PTR_W-1:0]   ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [ENTRY_W-1:0] sum_reg;
    logic [ENTRY_W-1:0] newest_reg;
    logic [ENTRY_W-1:0] prev_reg;

    logic signed [8:0]        err_reg;
    logic signed [NUM_W-1:0]  prod_reg;
    logic signed [16:0]       qd_reg;
    logic [ENTRY_W-1:0]       p_reg;
    logic [ENTRY_W-1:0]       i_reg;
    logic [ENTRY_W-1:0]       d_reg;
    logic                     out_valid_reg;
    logic [ENTRY_W-1:0]       out_data_reg;

    logic signed [17:0] mul_a;
    logic signed [15:0] mul_b;
    logic signed [33:0] mul_prod;
    logic signed [16:0] diff;
    logic [ENTRY_W-1:0] oldest;

    logic                     div_start;
    logic signed [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]         div_den;
    pidw_pkg::div_stat_t      div_stat;
    logic signed [NUM_W-1:0]  div_quot;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= pidw_pkg::TARGET_RST;
            frame_reg  <= pidw_pkg::FRAME_RST;
            gain_p_reg <= pidw_pkg::GAIN_P_RST;
            gain_i_reg <= pidw_pkg::GAIN_I_RST;
            gain_d_reg <= pidw_pkg::GAIN_D_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                pidw_pkg::REG_TARGET: target_reg <= cfg.data[pidw_pkg::TARGET_W-1:0];
                pidw_pkg::REG_FRAME:  frame_reg  <= cfg.data[pidw_pkg::FRAME_W-1:0];
                pidw_pkg::REG_GAIN_P: gain_p_reg <= cfg.data[pidw_pkg::GAIN_W-1:0];
                pidw_pkg::REG_GAIN_I: gain_i_reg <= cfg.data[pidw_pkg::GAIN_W-1:0];
                pidw_pkg::REG_GAIN_D: gain_d_reg <= cfg.data[pidw_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (state_reg)
            S_ENTRY:
            begin
                mul_a = {{9{err_reg[8]}}, err_reg};
                mul_b = {6'd0, frame_reg};
            end
            S_SHIFT:
            begin
                mul_a = {{9{err_reg[8]}}, err_reg};
                mul_b = {1'b0, gain_p_reg};
            end
            S_I_MUL:
            begin
                mul_a = {{2{sum_reg[ENTRY_W-1]}}, sum_reg};
                mul_b = {1'b0, gain_i_reg};
            end
            S_D_MUL:
            begin
                mul_a = {qd_reg[16], qd_reg};
                mul_b = {1'b0, gain_d_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;

    assign diff   = {newest_reg[ENTRY_W-1], newest_reg} - {prev_reg[ENTRY_W-1], prev_reg};
    assign oldest = (count_reg == CNT_FULL) ? rdata_reg : '0;

    always_comb
    begin
        case (state_reg) inside
            S_P_GO, S_I_GO, S_D_GO, S_E_GO: div_start = 1'b1;
            default:                        div_start = 1'b0;
        endcase
    end

    assign div_num = (state_reg == S_D_GO) ? {{15{diff[16]}}, diff} : prod_reg;
    assign div_den = (state_reg == S_D_GO) ? {6'd0, frame_reg} : SCALE_DEN;

    pidw_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == S_SHIFT)
        begin
            mem[ptr_reg] <= prod_reg[ENTRY_W-1:0];
        end
        rdata_reg <= mem[ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ptr_reg       <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            newest_reg    <= '0;
            prev_reg      <= '0;
            err_reg       <= '0;
            prod_reg      <= '0;
            qd_reg        <= '0;
            p_reg         <= '0;
            i_reg         <= '0;
            d_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && ctrl.ready && state_reg != S_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (meas.valid)
                    begin
                        err_reg   <= {1'b0, meas.measured_value} - {1'b0, target_reg};
                        state_reg <= S_ENTRY;
                    end
                end
                S_ENTRY:
                begin
                    prod_reg  <= mul_prod[NUM_W-1:0];
                    state_reg <= S_SHIFT;
                end
                S_SHIFT:
                begin
                    sum_reg    <= ENTRY_W'(sum_reg + prod_reg[ENTRY_W-1:0] - oldest);
                    prev_reg   <= newest_reg;
                    newest_reg <= prod_reg[ENTRY_W-1:0];
                    ptr_reg    <= (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;
                    if (count_reg != CNT_FULL)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                    prod_reg  <= mul_prod[NUM_W-1:0];
                    state_reg <= S_P_GO;
                end
                S_P_GO:
                begin
                    state_reg <= S_P_WAIT;
                end
                S_P_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        p_reg     <= div_quot[ENTRY_W-1:0];
                        state_reg <= S_I_MUL;
                    end
                end
                S_I_MUL:
                begin
                    prod_reg  <= mul_prod[NUM_W-1:0];
                    state_reg <= S_I_GO;
                end
                S_I_GO:
                begin
                    state_reg <= S_I_WAIT;
                end
                S_I_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        i_reg     <= div_quot[ENTRY_W-1:0];
                        state_reg <= S_D_GO;
                    end
                end
                S_D_GO:
                begin
                    state_reg <= S_D_WAIT;
                end
                S_D_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        qd_reg    <= div_quot[16:0];
                        state_reg <= S_D_MUL;
                    end
                end
                S_D_MUL:
                begin
                    prod_reg  <= mul_prod[NUM_W-1:0];
                    state_reg <= S_E_GO;
                end
                S_E_GO:
                begin
                    state_reg <= S_E_WAIT;
                end
                S_E_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        d_reg     <= div_quot[ENTRY_W-1:0];
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || ctrl.ready)
                    begin
                        out_data_reg  <= ENTRY_W'(p_reg + i_reg + d_reg);
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign meas.ready         = (state_reg == S_IDLE);
    assign ctrl.valid         = out_valid_reg;
    assign ctrl.control_value = out_data_reg;

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        meas.valid && meas.ready |=> !meas.ready)
        else $error("request accepted while another is in progress");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("window fill count beyond depth");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT && (!ctrl.valid || ctrl.ready) |=> ctrl.valid)
        else $error("result not presented after completion");

endmodule

FILE: rtl/pidw_div.sv
module pidw_div
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [pidw_pkg::DIV_NUM_W-1:0] num,
    input  logic [pidw_pkg::DIV_DEN_W-1:0]        den,
    output pidw_pkg::div_stat_t                  stat,
    output logic signed [pidw_pkg::DIV_NUM_W-1:0] quot
);

    localparam int NUM_W = pidw_pkg::DIV_NUM_W;
    localparam int DEN_W = pidw_pkg::DIV_DEN_W;
    localparam int STEPS = NUM_W / 2;
    localparam int CNT_W = $clog2(STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

    logic [NUM_W-1:0] mag_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic             neg_reg;
    logic             zero_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [DEN_W:0]   r1;
    logic [DEN_W:0]   r2;
    logic [DEN_W-1:0] s1;
    logic [DEN_W-1:0] rem_next;
    logic             q1;
    logic             q2;

    always_comb
    begin
        r1 = {rem_reg, mag_reg[NUM_W-1]};
        q1 = (r1 >= {1'b0, den_reg});
        s1 = q1 ? DEN_W'(r1 - {1'b0, den_reg}) : r1[DEN_W-1:0];
        r2 = {s1, mag_reg[NUM_W-2]};
        q2 = (r2 >= {1'b0, den_reg});
        rem_next = q2 ? DEN_W'(r2 - {1'b0, den_reg}) : r2[DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            neg_reg  <= 1'b0;
            zero_reg <= 1'b0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                mag_reg  <= num[NUM_W-1] ? NUM_W'(-num) : num;
                rem_reg  <= '0;
                den_reg  <= den;
                neg_reg  <= num[NUM_W-1];
                zero_reg <= (den == '0);
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                mag_reg <= {mag_reg[NUM_W-3:0], q1, q2};
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot = zero_reg ? '0 : (neg_reg ? NUM_W'(-mag_reg) : mag_reg);

endmodule
